### hw/rtl/svm_pkg.sv
// Shared constants, types and helper function of the stack machine executor.
package svm_pkg;

   localparam int MEM_WORDS  = 65536;
   localparam int TEXT_WORDS = 65536;
   localparam int MEM_AW     = $clog2(MEM_WORDS);
   localparam int TEXT_AW    = $clog2(TEXT_WORDS);
   localparam int BYTE_AW    = MEM_AW + 2;
   localparam int PTR_W      = BYTE_AW + 1;
   localparam int MEM_BYTES  = MEM_WORDS * 4;
   localparam int DATA_W     = 32;
   localparam int OP_W       = 6;
   localparam int STAT_W     = 3;
   localparam int NORM_W     = 37;

   localparam logic signed [NORM_W-1:0] MEM_BYTES_S = NORM_W'(MEM_BYTES);

   localparam logic [OP_W-1:0] OP_LEA  = 6'd0;
   localparam logic [OP_W-1:0] OP_IMM  = 6'd1;
   localparam logic [OP_W-1:0] OP_JMP  = 6'd2;
   localparam logic [OP_W-1:0] OP_CALL = 6'd3;
   localparam logic [OP_W-1:0] OP_JZ   = 6'd4;
   localparam logic [OP_W-1:0] OP_JNZ  = 6'd5;
   localparam logic [OP_W-1:0] OP_ENT  = 6'd6;
   localparam logic [OP_W-1:0] OP_ADJ  = 6'd7;
   localparam logic [OP_W-1:0] OP_LEV  = 6'd8;
   localparam logic [OP_W-1:0] OP_LI   = 6'd9;
   localparam logic [OP_W-1:0] OP_LC   = 6'd10;
   localparam logic [OP_W-1:0] OP_SI   = 6'd11;
   localparam logic [OP_W-1:0] OP_SC   = 6'd12;
   localparam logic [OP_W-1:0] OP_PUSH = 6'd13;
   localparam logic [OP_W-1:0] OP_OR   = 6'd14;
   localparam logic [OP_W-1:0] OP_XOR  = 6'd15;
   localparam logic [OP_W-1:0] OP_AND  = 6'd16;
   localparam logic [OP_W-1:0] OP_EQ   = 6'd17;
   localparam logic [OP_W-1:0] OP_NE   = 6'd18;
   localparam logic [OP_W-1:0] OP_LT   = 6'd19;
   localparam logic [OP_W-1:0] OP_GT   = 6'd20;
   localparam logic [OP_W-1:0] OP_LE   = 6'd21;
   localparam logic [OP_W-1:0] OP_GE   = 6'd22;
   localparam logic [OP_W-1:0] OP_SHL  = 6'd23;
   localparam logic [OP_W-1:0] OP_SHR  = 6'd24;
   localparam logic [OP_W-1:0] OP_ADD  = 6'd25;
   localparam logic [OP_W-1:0] OP_SUB  = 6'd26;
   localparam logic [OP_W-1:0] OP_MUL  = 6'd27;
   localparam logic [OP_W-1:0] OP_DIV  = 6'd28;
   localparam logic [OP_W-1:0] OP_MOD  = 6'd29;
   localparam logic [OP_W-1:0] OP_EXIT = 6'd37;

   localparam logic [STAT_W-1:0] STAT_RUN    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EXIT   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_DIVZ   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_UNSUP  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_HALTED = 3'd4;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [MEM_AW-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic              start;
      logic              is_mod;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   // Keeps a pointer in 0..MEM_BYTES and wraps anything outside that range.
   function automatic logic [PTR_W-1:0] ptr_norm(input logic signed [NORM_W-1:0] s);
      logic [PTR_W-1:0] r;
      if (s >= 0 && s <= MEM_BYTES_S) begin
         r = s[PTR_W-1:0];
      end else begin
         r = {1'b0, s[BYTE_AW-1:0]};
      end
      return r;
   endfunction

endpackage

### hw/rtl/svm_dmem.sv
// Single-port data memory with registered read data.
module svm_dmem (
   input  logic                              clock,
   input  svm_pkg::mem_req_type              mem_req,
   output logic [svm_pkg::DATA_W-1:0]        mem_rdata
);

   logic [svm_pkg::DATA_W-1:0] mem_array [svm_pkg::MEM_WORDS];
   logic [svm_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.en && mem_req.we) begin
         mem_array[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.en && !mem_req.we) begin
         rdata_ff <= mem_array[mem_req.addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

### hw/rtl/svm_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module svm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  svm_pkg::div_req_type       div_req,
   output logic                       div_done,
   output logic [svm_pkg::DATA_W-1:0] div_result
);

   localparam int CNT_W = $clog2(svm_pkg::DATA_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [svm_pkg::DATA_W-1:0]  quot_ff, quot_in;
   logic [svm_pkg::DATA_W-1:0]  rem_ff, rem_in;
   logic [svm_pkg::DATA_W-1:0]  dvs_ff, dvs_in;
   logic                        negq_ff, negq_in;
   logic                        negr_ff, negr_in;
   logic                        mod_ff, mod_in;
   logic [svm_pkg::DATA_W:0]    shifted;
   logic                        fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      mod_in  = mod_ff;
      shifted = {rem_ff, quot_ff[svm_pkg::DATA_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '1;
         quot_in = div_req.dividend[svm_pkg::DATA_W-1] ? (0 - div_req.dividend)
                                                     : div_req.dividend;
         dvs_in  = div_req.divisor[svm_pkg::DATA_W-1] ? (0 - div_req.divisor)
                                                    : div_req.divisor;
         rem_in  = '0;
         negr_in = div_req.dividend[svm_pkg::DATA_W-1];
         negq_in = div_req.dividend[svm_pkg::DATA_W-1] ^ div_req.divisor[svm_pkg::DATA_W-1];
         mod_in  = div_req.is_mod;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = svm_pkg::DATA_W'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[svm_pkg::DATA_W-1:0];
         end
         quot_in = {quot_ff[svm_pkg::DATA_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      mod_ff  <= mod_in;
   end

   assign div_done   = done_ff;
   assign div_result = mod_ff ? (negr_ff ? (0 - rem_ff) : rem_ff)
                              : (negq_ff ? (0 - quot_ff) : quot_ff);

endmodule

### hw/rtl/stack_vm_instruction_executor_unit.sv
// Each instruction is accepted in IDLE and then executes in EXEC on the read data.
// LEV and SC pass through EXEC2 for a second memory access; DIV and MOD wait in DIV for
// the bit-serial divider, except when the divisor is zero or minus one.
// One instruction is in flight at a time; the single-port memory allows one access a cycle.
// After reset a clearing pass zeroes all 65536 memory words, one per cycle,
// and no word is accepted until it ends; registers reset at once.
module stack_vm_instruction_executor_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [svm_pkg::OP_W-1:0]            req_opcode,
   input  logic signed [svm_pkg::DATA_W-1:0]   req_operand,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [svm_pkg::TEXT_AW-1:0]         rsp_next_pc,
   output logic signed [svm_pkg::DATA_W-1:0]   rsp_acc_value,
   output logic [svm_pkg::PTR_W-1:0]           rsp_stack_top_addr,
   output logic [svm_pkg::STAT_W-1:0]          rsp_status,
   output logic signed [svm_pkg::DATA_W-1:0]   rsp_exit_code
);

   localparam int DW = svm_pkg::DATA_W;
   localparam int PW = svm_pkg::PTR_W;
   localparam int NW = svm_pkg::NORM_W;
   localparam int AW = svm_pkg::MEM_AW;
   localparam int BW = svm_pkg::BYTE_AW;
   localparam int TW = svm_pkg::TEXT_AW;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_EXEC2 = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   localparam logic signed [NW-1:0] FOUR = NW'(4);

   logic [2:0]                 state_ff, state_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [svm_pkg::OP_W-1:0]   op_ff, op_in;
   logic [DW-1:0]              opnd_ff, opnd_in;
   logic [DW-1:0]              tmp_ff, tmp_in;
   logic [DW-1:0]              acc_ff, acc_in;
   logic [TW-1:0]              pc_ff, pc_in;
   logic [PW-1:0]              sp_ff, sp_in;
   logic [PW-1:0]              fp_ff, fp_in;
   logic                       halted_ff, halted_in;
   logic                       rsp_valid_ff;
   logic [TW-1:0]              rsp_pc_ff;
   logic [DW-1:0]              rsp_acc_ff;
   logic [PW-1:0]              rsp_sp_ff;
   logic [svm_pkg::STAT_W-1:0] rsp_stat_ff;
   logic [DW-1:0]              rsp_exit_ff;

   svm_pkg::mem_req_type       mem_req;
   svm_pkg::div_req_type       div_req;
   logic [DW-1:0]              mem_rdata;
   logic                       div_done;
   logic [DW-1:0]              div_result;

   logic                       accept, fin_ok, done, commit;
   logic [svm_pkg::STAT_W-1:0] res_status;
   logic [DW-1:0]              res_exit;
   logic [TW-1:0]              pc1, pc2, tgt;
   logic signed [NW-1:0]       sp_s, fp_s, opnd4;
   logic [PW-1:0]              sp_dec, sp_inc, lev_sp1, lev_sp2;
   logic [DW-1:0]              alu_res, lc_byte, sc_mask, sc_data;
   logic [4:0]                 sh;
   logic [4:0]                 lane_bits;

   svm_dmem u_dmem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   svm_div u_div (
      .clock      (clock),
      .reset      (reset),
      .div_req    (div_req),
      .div_done   (div_done),
      .div_result (div_result)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fin_ok    = !rsp_valid_ff || rsp_ready;
   assign commit    = done && fin_ok;

   assign pc1     = pc_ff + TW'(1);
   assign pc2     = pc_ff + TW'(2);
   assign tgt     = opnd_ff[TW-1:0];
   assign sp_s    = $signed({{(NW-PW){1'b0}}, sp_ff});
   assign fp_s    = $signed({{(NW-PW){1'b0}}, fp_ff});
   assign opnd4   = $signed({{(NW-DW-2){opnd_ff[DW-1]}}, opnd_ff, 2'b00});
   assign sp_dec  = svm_pkg::ptr_norm(sp_s - FOUR);
   assign sp_inc  = svm_pkg::ptr_norm(sp_s + FOUR);
   assign lev_sp1 = svm_pkg::ptr_norm(fp_s + FOUR);
   assign lev_sp2 = svm_pkg::ptr_norm($signed({{(NW-PW){1'b0}}, lev_sp1}) + FOUR);
   assign sh      = acc_ff[4:0];

   // Binary operations: the popped word is the left operand.
   always_comb begin
      unique case (op_ff)
         svm_pkg::OP_OR:  alu_res = mem_rdata | acc_ff;
         svm_pkg::OP_XOR: alu_res = mem_rdata ^ acc_ff;
         svm_pkg::OP_AND: alu_res = mem_rdata & acc_ff;
         svm_pkg::OP_EQ:  alu_res = {{(DW-1){1'b0}}, mem_rdata == acc_ff};
         svm_pkg::OP_NE:  alu_res = {{(DW-1){1'b0}}, mem_rdata != acc_ff};
         svm_pkg::OP_LT:  alu_res = {{(DW-1){1'b0}}, $signed(mem_rdata) < $signed(acc_ff)};
         svm_pkg::OP_GT:  alu_res = {{(DW-1){1'b0}}, $signed(mem_rdata) > $signed(acc_ff)};
         svm_pkg::OP_LE:  alu_res = {{(DW-1){1'b0}}, $signed(mem_rdata) <= $signed(acc_ff)};
         svm_pkg::OP_GE:  alu_res = {{(DW-1){1'b0}}, $signed(mem_rdata) >= $signed(acc_ff)};
         svm_pkg::OP_SHL: alu_res = mem_rdata << sh;
         svm_pkg::OP_SHR: alu_res = $unsigned($signed(mem_rdata) >>> sh);
         svm_pkg::OP_ADD: alu_res = mem_rdata + acc_ff;
         svm_pkg::OP_SUB: alu_res = mem_rdata - acc_ff;
         svm_pkg::OP_MUL: alu_res = mem_rdata * acc_ff;
         default:         alu_res = '0;
      endcase
   end

   assign lc_byte   = {24'b0, 8'(mem_rdata >> {acc_ff[1:0], 3'b000})};
   assign lane_bits = {tmp_ff[1:0], 3'b000};
   assign sc_mask   = ~(DW'(8'hFF) << lane_bits);
   assign sc_data   = (mem_rdata & sc_mask) | (DW'(acc_ff[7:0]) << lane_bits);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      op_in      = op_ff;
      opnd_in    = opnd_ff;
      tmp_in     = tmp_ff;
      acc_in     = acc_ff;
      pc_in      = pc_ff;
      sp_in      = sp_ff;
      fp_in      = fp_ff;
      halted_in  = halted_ff;
      mem_req    = '0;
      div_req    = '0;
      done       = 1'b0;
      res_status = svm_pkg::STAT_RUN;
      res_exit   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.en   = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = clr_ff;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               opnd_in  = req_operand;
               state_in = ST_EXEC;
               if (!halted_ff) begin
                  // Pushes write at once; pops and loads start their read here.
                  priority if (req_opcode == svm_pkg::OP_CALL ||
                               req_opcode == svm_pkg::OP_ENT ||
                               req_opcode == svm_pkg::OP_PUSH) begin
                     mem_req.en   = 1'b1;
                     mem_req.we   = 1'b1;
                     mem_req.addr = sp_dec[BW-1:2];
                     if (req_opcode == svm_pkg::OP_CALL) begin
                        mem_req.wdata = DW'(pc2);
                     end else if (req_opcode == svm_pkg::OP_ENT) begin
                        mem_req.wdata = DW'(fp_ff);
                     end else begin
                        mem_req.wdata = acc_ff;
                     end
                  end else if (req_opcode == svm_pkg::OP_LEV) begin
                     mem_req.en   = 1'b1;
                     mem_req.addr = fp_ff[BW-1:2];
                  end else if (req_opcode == svm_pkg::OP_LI ||
                               req_opcode == svm_pkg::OP_LC) begin
                     mem_req.en   = 1'b1;
                     mem_req.addr = acc_ff[BW-1:2];
                  end else if (req_opcode == svm_pkg::OP_SI ||
                               req_opcode == svm_pkg::OP_SC ||
                               req_opcode == svm_pkg::OP_EXIT ||
                               (req_opcode >= svm_pkg::OP_OR &&
                                req_opcode <= svm_pkg::OP_MOD)) begin
                     mem_req.en   = 1'b1;
                     mem_req.addr = sp_ff[BW-1:2];
                  end else begin
                     mem_req.en = 1'b0;
                  end
               end
            end
         end
         ST_EXEC: begin
            if (halted_ff) begin
               done       = 1'b1;
               res_status = svm_pkg::STAT_HALTED;
            end else begin
               unique case (op_ff)
                  svm_pkg::OP_LEA: begin
                     acc_in = DW'(fp_ff) + {opnd_ff[DW-3:0], 2'b00};
                     pc_in  = pc2;
                     done   = 1'b1;
                  end
                  svm_pkg::OP_IMM: begin
                     acc_in = opnd_ff;
                     pc_in  = pc2;
                     done   = 1'b1;
                  end
                  svm_pkg::OP_JMP: begin
                     pc_in = tgt;
                     done  = 1'b1;
                  end
                  svm_pkg::OP_CALL: begin
                     sp_in = sp_dec;
                     pc_in = tgt;
                     done  = 1'b1;
                  end
                  svm_pkg::OP_JZ: begin
                     pc_in = (acc_ff != '0) ? pc2 : tgt;
                     done  = 1'b1;
                  end
                  svm_pkg::OP_JNZ: begin
                     pc_in = (acc_ff != '0) ? tgt : pc2;
                     done  = 1'b1;
                  end
                  svm_pkg::OP_ENT: begin
                     fp_in = sp_dec;
                     sp_in = svm_pkg::ptr_norm($signed({{(NW-PW){1'b0}}, sp_dec}) - opnd4);
                     pc_in = pc2;
                     done  = 1'b1;
                  end
                  svm_pkg::OP_ADJ: begin
                     sp_in = svm_pkg::ptr_norm(sp_s + opnd4);
                     pc_in = pc2;
                     done  = 1'b1;
                  end
                  svm_pkg::OP_LEV: begin
                     tmp_in       = mem_rdata;
                     mem_req.en   = 1'b1;
                     mem_req.addr = lev_sp1[BW-1:2];
                     state_in     = ST_EXEC2;
                  end
                  svm_pkg::OP_LI: begin
                     acc_in = mem_rdata;
                     pc_in  = pc1;
                     done   = 1'b1;
                  end
                  svm_pkg::OP_LC: begin
                     acc_in = {{(DW-8){lc_byte[7]}}, lc_byte[7:0]};
                     pc_in  = pc1;
                     done   = 1'b1;
                  end
                  svm_pkg::OP_SI: begin
                     mem_req.en    = fin_ok;
                     mem_req.we    = 1'b1;
                     mem_req.addr  = mem_rdata[BW-1:2];
                     mem_req.wdata = acc_ff;
                     sp_in         = sp_inc;
                     pc_in         = pc1;
                     done          = 1'b1;
                  end
                  svm_pkg::OP_SC: begin
                     tmp_in       = mem_rdata;
                     mem_req.en   = 1'b1;
                     mem_req.addr = mem_rdata[BW-1:2];
                     state_in     = ST_EXEC2;
                  end
                  svm_pkg::OP_PUSH: begin
                     sp_in = sp_dec;
                     pc_in = pc1;
                     done  = 1'b1;
                  end
                  svm_pkg::OP_OR, svm_pkg::OP_XOR, svm_pkg::OP_AND, svm_pkg::OP_EQ,
                  svm_pkg::OP_NE, svm_pkg::OP_LT, svm_pkg::OP_GT, svm_pkg::OP_LE,
                  svm_pkg::OP_GE, svm_pkg::OP_SHL, svm_pkg::OP_SHR, svm_pkg::OP_ADD,
                  svm_pkg::OP_SUB, svm_pkg::OP_MUL: begin
                     acc_in = alu_res;
                     sp_in  = sp_inc;
                     pc_in  = pc1;
                     done   = 1'b1;
                  end
                  svm_pkg::OP_DIV, svm_pkg::OP_MOD: begin
                     if (acc_ff == '0) begin
                        sp_in      = sp_inc;
                        pc_in      = pc1;
                        halted_in  = 1'b1;
                        res_status = svm_pkg::STAT_DIVZ;
                        done       = 1'b1;
                     end else if (acc_ff == '1) begin
                        // Divisor of minus one: DIV negates, so the most negative value wraps; MOD gives zero.
                        acc_in = (op_ff == svm_pkg::OP_DIV) ? (0 - mem_rdata) : '0;
                        sp_in  = sp_inc;
                        pc_in  = pc1;
                        done   = 1'b1;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.is_mod   = (op_ff == svm_pkg::OP_MOD);
                        div_req.dividend = mem_rdata;
                        div_req.divisor  = acc_ff;
                        state_in         = ST_DIV;
                     end
                  end
                  svm_pkg::OP_EXIT: begin
                     res_exit   = mem_rdata;
                     res_status = svm_pkg::STAT_EXIT;
                     halted_in  = 1'b1;
                     pc_in      = pc1;
                     done       = 1'b1;
                  end
                  default: begin
                     res_status = svm_pkg::STAT_UNSUP;
                     halted_in  = 1'b1;
                     pc_in      = pc1;
                     done       = 1'b1;
                  end
               endcase
            end
         end
         ST_EXEC2: begin
            done = 1'b1;
            if (op_ff == svm_pkg::OP_LEV) begin
               sp_in = lev_sp2;
               fp_in = svm_pkg::ptr_norm($signed({{(NW-DW){1'b0}}, tmp_ff}));
               pc_in = mem_rdata[TW-1:0];
            end else begin
               mem_req.en    = fin_ok;
               mem_req.we    = 1'b1;
               mem_req.addr  = tmp_ff[BW-1:2];
               mem_req.wdata = sc_data;
               acc_in        = {{(DW-8){acc_ff[7]}}, acc_ff[7:0]};
               sp_in         = sp_inc;
               pc_in         = pc1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               acc_in = div_result;
               sp_in  = sp_inc;
               pc_in  = pc1;
               done   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Architectural state moves only when the result word can be loaded.
      if (done) begin
         if (fin_ok) begin
            state_in = ST_IDLE;
         end else begin
            acc_in    = acc_ff;
            pc_in     = pc_ff;
            sp_in     = sp_ff;
            fp_in     = fp_ff;
            halted_in = halted_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         acc_ff       <= '0;
         pc_ff        <= '0;
         sp_ff        <= PW'(svm_pkg::MEM_BYTES);
         fp_ff        <= PW'(svm_pkg::MEM_BYTES);
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         acc_ff    <= acc_in;
         pc_ff     <= pc_in;
         sp_ff     <= sp_in;
         fp_ff     <= fp_in;
         halted_ff <= halted_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      opnd_ff <= opnd_in;
      tmp_ff  <= tmp_in;
      if (commit) begin
         rsp_pc_ff   <= pc_in;
         rsp_acc_ff  <= acc_in;
         rsp_sp_ff   <= sp_in;
         rsp_stat_ff <= res_status;
         rsp_exit_ff <= res_exit;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_pc        = rsp_pc_ff;
   assign rsp_acc_value      = $signed(rsp_acc_ff);
   assign rsp_stack_top_addr = rsp_sp_ff;
   assign rsp_status         = rsp_stat_ff;
   assign rsp_exit_code      = $signed(rsp_exit_ff);

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      (sp_ff <= PW'(svm_pkg::MEM_BYTES)) && (fp_ff <= PW'(svm_pkg::MEM_BYTES)))
      else $error("stack or frame pointer beyond memory size");
   assert property (@(posedge clock) disable iff (reset) !$fell(halted_ff))
      else $error("halt flag cleared outside reset");
   assert property (@(posedge clock) disable iff (reset)
      commit && (res_status != svm_pkg::STAT_RUN) |=> halted_ff)
      else $error("non-running status without halt");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("word accepted during memory clear");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !mem_req.en)
      else $error("memory access while dividing");
`endif

endmodule

### tb/stack_vm_executor_checker.sv
`timescale 1ns / 100ps
// Checker for the stack machine executor: predicts each result and compares it.
module stack_vm_executor_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [svm_pkg::OP_W-1:0]           req_opcode,
   input  logic signed [svm_pkg::DATA_W-1:0]  req_operand,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [svm_pkg::TEXT_AW-1:0]        rsp_next_pc,
   input  logic signed [svm_pkg::DATA_W-1:0]  rsp_acc_value,
   input  logic [svm_pkg::PTR_W-1:0]          rsp_stack_top_addr,
   input  logic [svm_pkg::STAT_W-1:0]         rsp_status,
   input  logic signed [svm_pkg::DATA_W-1:0]  rsp_exit_code,
   output int                                 fail_count,
   output int                                 pending
);

   localparam int DW = svm_pkg::DATA_W;
   localparam int PW = svm_pkg::PTR_W;
   localparam int TW = svm_pkg::TEXT_AW;
   localparam int AW = svm_pkg::MEM_AW;
   localparam int BW = svm_pkg::BYTE_AW;
   localparam int OW = svm_pkg::OP_W;
   localparam int SW = svm_pkg::STAT_W;

   typedef struct packed {
      logic [TW-1:0] pc;
      logic [DW-1:0] acc;
      logic [PW-1:0] sp;
      logic [SW-1:0] st;
      logic [DW-1:0] exit_val;
   } vm_result_type;

   vm_result_type  expected_results[$];
   logic [DW-1:0]  vm_mem [svm_pkg::MEM_WORDS];
   logic [DW-1:0]  vm_acc;
   logic [TW-1:0]  vm_pc;
   logic [PW-1:0]  vm_sp;
   logic [PW-1:0]  vm_fp;
   logic           vm_halted;

   function automatic logic [PW-1:0] wrap_ptr(longint s);
      longint r;
      if (s >= 0 && s <= svm_pkg::MEM_BYTES) return PW'(s);
      r = s % svm_pkg::MEM_BYTES;
      if (r < 0) r += svm_pkg::MEM_BYTES;
      return PW'(r);
   endfunction

   // Word index of a byte address; the memory wraps at its size.
   function automatic logic [AW-1:0] word_of(logic [DW-1:0] a);
      return a[BW-1:2];
   endfunction

   function automatic logic [DW-1:0] sext8(logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

   task automatic stack_push(logic [DW-1:0] v);
      vm_sp = wrap_ptr(longint'(vm_sp) - 4);
      vm_mem[word_of(DW'(vm_sp))] = v;
   endtask

   task automatic stack_pop(output logic [DW-1:0] v);
      v = vm_mem[word_of(DW'(vm_sp))];
      vm_sp = wrap_ptr(longint'(vm_sp) + 4);
   endtask

   task automatic execute_word(logic [OW-1:0] op, logic [DW-1:0] opnd,
                               output vm_result_type res);
      logic [TW-1:0] pc1, pc2;
      logic [DW-1:0] l, a, w;
      logic [4:0]    sh;
      logic [1:0]    lane;
      int            sl, sr;
      longint        sopnd;
      res = '0;
      pc1 = vm_pc + 1'b1;
      pc2 = vm_pc + 2'd2;
      sopnd = longint'($signed(opnd));
      if (vm_halted) begin
         res.st = svm_pkg::STAT_HALTED;
      end else if (op <= svm_pkg::OP_LEV) begin
         case (op)
            svm_pkg::OP_LEA: begin
               vm_acc = DW'(vm_fp) + (opnd << 2);
               vm_pc = pc2;
            end
            svm_pkg::OP_IMM: begin
               vm_acc = opnd;
               vm_pc = pc2;
            end
            svm_pkg::OP_JMP: vm_pc = opnd[TW-1:0];
            svm_pkg::OP_CALL: begin
               stack_push(DW'(pc2));
               vm_pc = opnd[TW-1:0];
            end
            svm_pkg::OP_JZ: vm_pc = (vm_acc != 0) ? pc2 : opnd[TW-1:0];
            svm_pkg::OP_JNZ: vm_pc = (vm_acc != 0) ? opnd[TW-1:0] : pc2;
            svm_pkg::OP_ENT: begin
               stack_push(DW'(vm_fp));
               vm_fp = vm_sp;
               vm_sp = wrap_ptr(longint'(vm_sp) - 4 * sopnd);
               vm_pc = pc2;
            end
            svm_pkg::OP_ADJ: begin
               vm_sp = wrap_ptr(longint'(vm_sp) + 4 * sopnd);
               vm_pc = pc2;
            end
            default: begin
               vm_sp = vm_fp;
               stack_pop(l);
               vm_fp = wrap_ptr(longint'(l));
               stack_pop(l);
               vm_pc = l[TW-1:0];
            end
         endcase
      end else if (op <= svm_pkg::OP_PUSH) begin
         lane = vm_acc[1:0];
         case (op)
            svm_pkg::OP_LI: vm_acc = vm_mem[word_of(vm_acc)];
            svm_pkg::OP_LC: begin
               w = vm_mem[word_of(vm_acc)] >> (8 * lane);
               vm_acc = sext8(w[7:0]);
            end
            svm_pkg::OP_SI: begin
               stack_pop(a);
               vm_mem[word_of(a)] = vm_acc;
            end
            svm_pkg::OP_SC: begin
               stack_pop(a);
               w = vm_mem[word_of(a)];
               w[8 * a[1:0] +: 8] = vm_acc[7:0];
               vm_mem[word_of(a)] = w;
               vm_acc = sext8(vm_acc[7:0]);
            end
            default: stack_push(vm_acc);
         endcase
         vm_pc = pc1;
      end else if (op <= svm_pkg::OP_MOD) begin
         stack_pop(l);
         sl = $signed(l);
         sr = $signed(vm_acc);
         sh = vm_acc[4:0];
         vm_pc = pc1;
         case (op)
            svm_pkg::OP_OR:  vm_acc = l | vm_acc;
            svm_pkg::OP_XOR: vm_acc = l ^ vm_acc;
            svm_pkg::OP_AND: vm_acc = l & vm_acc;
            svm_pkg::OP_EQ:  vm_acc = DW'(l == vm_acc);
            svm_pkg::OP_NE:  vm_acc = DW'(l != vm_acc);
            svm_pkg::OP_LT:  vm_acc = DW'(sl < sr);
            svm_pkg::OP_GT:  vm_acc = DW'(sl > sr);
            svm_pkg::OP_LE:  vm_acc = DW'(sl <= sr);
            svm_pkg::OP_GE:  vm_acc = DW'(sl >= sr);
            svm_pkg::OP_SHL: vm_acc = l << sh;
            svm_pkg::OP_SHR: vm_acc = DW'($signed(l) >>> sh);
            svm_pkg::OP_ADD: vm_acc = l + vm_acc;
            svm_pkg::OP_SUB: vm_acc = l - vm_acc;
            svm_pkg::OP_MUL: vm_acc = l * vm_acc;
            default: begin
               if (vm_acc == 0) begin
                  res.st = svm_pkg::STAT_DIVZ;
                  vm_halted = 1'b1;
               end else if (sr == -1) begin
                  vm_acc = (op == svm_pkg::OP_DIV) ? (0 - l) : '0;
               end else begin
                  vm_acc = (op == svm_pkg::OP_DIV) ? DW'(sl / sr) : DW'(sl % sr);
               end
            end
         endcase
      end else if (op == svm_pkg::OP_EXIT) begin
         res.exit_val = vm_mem[word_of(DW'(vm_sp))];
         vm_pc = pc1;
         res.st = svm_pkg::STAT_EXIT;
         vm_halted = 1'b1;
      end else begin
         vm_pc = pc1;
         res.st = svm_pkg::STAT_UNSUP;
         vm_halted = 1'b1;
      end
      res.pc = vm_pc;
      res.acc = vm_acc;
      res.sp = vm_sp;
   endtask

   task automatic report(string field, logic [DW-1:0] exp_v, logic [DW-1:0] got_v);
      $display("%0t: %s expected %h got %h", $realtime, field, exp_v, got_v);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      foreach (vm_mem[i]) vm_mem[i] = '0;
      vm_acc = '0;
      vm_pc = '0;
      vm_sp = PW'(svm_pkg::MEM_BYTES);
      vm_fp = PW'(svm_pkg::MEM_BYTES);
      vm_halted = 1'b0;
   end

   always @(posedge clock) begin
      vm_result_type r, e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            execute_word(req_opcode, req_operand, r);
            expected_results.push_back(r);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report("unexpected word, pc", '0, DW'(rsp_next_pc));
            end else begin
               e = expected_results.pop_front();
               if (rsp_next_pc !== e.pc) report("next_pc", DW'(e.pc), DW'(rsp_next_pc));
               if (rsp_acc_value !== e.acc) report("acc_value", e.acc, rsp_acc_value);
               if (rsp_stack_top_addr !== e.sp)
                  report("stack_top_addr", DW'(e.sp), DW'(rsp_stack_top_addr));
               if (rsp_status !== e.st) report("status", DW'(e.st), DW'(rsp_status));
               if (rsp_exit_code !== e.exit_val) report("exit_code", e.exit_val, rsp_exit_code);
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

### tb/tb_stack_vm_instruction_executor_unit.sv
`timescale 1ns / 100ps
// Testbench top for the stack machine executor: stimulus, handshakes and verdict.
module tb_stack_vm_instruction_executor_unit;

   localparam int DW = svm_pkg::DATA_W;
   localparam int OW = svm_pkg::OP_W;
   localparam int CYCLE_LIMIT = 700000;
   localparam int RANDOM_WORDS = 1400;
   localparam logic [DW-1:0] INT_MIN = 32'h8000_0000;
   localparam logic [DW-1:0] INT_MAX = 32'h7FFF_FFFF;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [OW-1:0]                       req_opcode;
   logic signed [DW-1:0]                req_operand;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [svm_pkg::TEXT_AW-1:0]         rsp_next_pc;
   logic signed [DW-1:0]                rsp_acc_value;
   logic [svm_pkg::PTR_W-1:0]           rsp_stack_top_addr;
   logic [svm_pkg::STAT_W-1:0]          rsp_status;
   logic signed [DW-1:0]                rsp_exit_code;
   int                                  fail_count;
   int                                  pending;
   int                                  cycle_count;
   int                                  words_sent;
   logic                                idle_on;
   logic                                hold_request;
   int                                  hold_left;

   stack_vm_instruction_executor_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_operand        (req_operand),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_acc_value      (rsp_acc_value),
      .rsp_stack_top_addr (rsp_stack_top_addr),
      .rsp_status         (rsp_status),
      .rsp_exit_code      (rsp_exit_code)
   );

   stack_vm_executor_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_operand        (req_operand),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_acc_value      (rsp_acc_value),
      .rsp_stack_top_addr (rsp_stack_top_addr),
      .rsp_status         (rsp_status),
      .rsp_exit_code      (rsp_exit_code),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = 400;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on) begin
         rsp_ready <= ($urandom_range(99) >= 25);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [DW-1:0] pick_operand();
      case ($urandom_range(7))
         0: return INT_MIN;
         1: return INT_MAX;
         2: return '1;
         3: return '0;
         4, 5: return DW'($urandom_range(64));
         default: return $urandom();
      endcase
   endfunction

   // Offers one word and holds it until the block takes it; called at a falling edge.
   task automatic send_word(logic [OW-1:0] op, logic [DW-1:0] opnd);
      if (idle_on && $urandom_range(99) < 25) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_operand = opnd;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic divide_sequence(logic [DW-1:0] num, logic [DW-1:0] den,
                                  logic [OW-1:0] op);
      send_word(svm_pkg::OP_IMM, num);
      send_word(svm_pkg::OP_PUSH, '0);
      send_word(svm_pkg::OP_IMM, den);
      send_word(op, '0);
   endtask

   task automatic random_sequence();
      logic [DW-1:0] addr, den;
      int kind;
      kind = $urandom_range(99);
      if (kind < 12) begin
         case ($urandom_range(3))
            0: den = '1;
            1: den = DW'($urandom_range(1, 9));
            default: den = $urandom() | 32'h1;
         endcase
         divide_sequence(($urandom_range(3) == 0) ? INT_MIN : pick_operand(), den,
                         $urandom_range(1) ? svm_pkg::OP_DIV : svm_pkg::OP_MOD);
      end else if (kind < 30) begin
         addr = $urandom_range(1) ? DW'($urandom_range(255)) : $urandom();
         send_word(svm_pkg::OP_IMM, addr);
         send_word(svm_pkg::OP_PUSH, '0);
         send_word(svm_pkg::OP_IMM, pick_operand());
         send_word($urandom_range(1) ? svm_pkg::OP_SI : svm_pkg::OP_SC, '0);
         send_word(svm_pkg::OP_IMM, addr ^ DW'($urandom_range(3)));
         send_word($urandom_range(1) ? svm_pkg::OP_LI : svm_pkg::OP_LC, '0);
      end else if (kind < 42) begin
         send_word(svm_pkg::OP_CALL, pick_operand());
         send_word(svm_pkg::OP_ENT, DW'($urandom_range(8)));
         send_word(svm_pkg::OP_LEA, DW'($urandom_range(8)) - 4);
         send_word(svm_pkg::OP_LI, '0);
         send_word(svm_pkg::OP_PUSH, '0);
         send_word(svm_pkg::OP_ADJ, DW'(1));
         send_word(svm_pkg::OP_LEV, '0);
      end else begin
         send_word(OW'($urandom_range(svm_pkg::OP_MUL)), pick_operand());
      end
   endtask

   initial begin
      int halt_kind;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = '0;
      req_operand = '0;
      idle_on = 1'b1;
      hold_request = 1'b0;
      hold_left = 0;
      cycle_count = 0;
      words_sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: overflow, the division corner cases, shifts, byte lanes and frames.
      send_word(svm_pkg::OP_IMM, INT_MAX);
      send_word(svm_pkg::OP_PUSH, '0);
      send_word(svm_pkg::OP_IMM, 32'd1);
      send_word(svm_pkg::OP_ADD, '0);
      divide_sequence(INT_MIN, '1, svm_pkg::OP_DIV);
      divide_sequence(INT_MIN, '1, svm_pkg::OP_MOD);
      divide_sequence(32'hFFFF_FFF9, 32'd2, svm_pkg::OP_MOD);
      send_word(svm_pkg::OP_IMM, INT_MIN);
      send_word(svm_pkg::OP_PUSH, '0);
      send_word(svm_pkg::OP_IMM, 32'd31);
      send_word(svm_pkg::OP_SHR, '0);
      send_word(svm_pkg::OP_IMM, 32'h0000_0103);
      send_word(svm_pkg::OP_PUSH, '0);
      send_word(svm_pkg::OP_IMM, 32'h0000_0080);
      send_word(svm_pkg::OP_SC, '0);
      send_word(svm_pkg::OP_IMM, 32'h0000_0103);
      send_word(svm_pkg::OP_LC, '0);
      send_word(svm_pkg::OP_ENT, INT_MIN);
      send_word(svm_pkg::OP_LEA, INT_MAX);
      send_word(svm_pkg::OP_LEV, '0);
      send_word(svm_pkg::OP_JZ, '1);

      while (words_sent < RANDOM_WORDS) begin
         idle_on = !(words_sent >= 500 && words_sent < 800);
         if (words_sent >= 300 && words_sent < 320 && hold_left == 0) hold_request = 1'b1;
         if (words_sent >= 900 && words_sent < 910) begin
            req_valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         random_sequence();
      end

      // Only one halt can be observed per run, so its cause is chosen at random.
      halt_kind = $urandom_range(2);
      case (halt_kind)
         0: send_word(svm_pkg::OP_EXIT, $urandom());
         1: divide_sequence($urandom(), '0,
                            $urandom_range(1) ? svm_pkg::OP_DIV : svm_pkg::OP_MOD);
         default: send_word($urandom_range(1)
                               ? OW'($urandom_range(svm_pkg::OP_MOD + 1, svm_pkg::OP_EXIT - 1))
                               : OW'($urandom_range(svm_pkg::OP_EXIT + 1, 63)),
                            $urandom());
      endcase
      repeat (24) send_word(OW'($urandom_range(63)), $urandom());
      req_valid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
